### hw/rtl/ismu_pkg.sv
// Shared types and constants for the Ising Metropolis update unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package ismu_pkg;

	localparam int SITE_W      = 12;
	localparam int RAND_W      = 16;
	localparam int THR_W       = 17;
	localparam int REG_W       = 2 * THR_W;
	localparam int REG_COUNT   = 5;
	localparam int CFG_IDX_W   = 3;
	localparam int SPIN_SUM_W  = 14;
	localparam int BOND_SUM_W  = 15;
	localparam int READ_COUNT  = 5;
	localparam int RECIP_SHIFT = 24;
	localparam int IN_DATA_W   = 32;
	localparam int OUT_DATA_W  = 32;

	localparam logic [REG_W-1:0] ACCEPT_RESET [REG_COUNT] = '{
		34'd4295032832, 34'd4295032832, 34'd4295032832, 34'd0, 34'd0
	};

	typedef struct packed {
		logic clear;
		logic load;
		logic div;
		logic rem;
		logic nbr;
		logic rd;
		logic eval;
	} ismu_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic rd_done;
		logic out_free;
	} ismu_status_t;

endpackage

### hw/rtl/ismu_controller.sv
// Sequencing state machine of the Ising Metropolis update unit.
// Depends on ismu_pkg for the command and status structs.
module ismu_controller (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  ismu_pkg::ismu_status_t status,
	output ismu_pkg::ismu_cmd_t    cmd
);
	import ismu_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_REM   = 3'd3;
	localparam logic [2:0] S_NBR   = 3'd4;
	localparam logic [2:0] S_READ  = 3'd5;
	localparam logic [2:0] S_EVAL  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		s_axis_tready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clear_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					cmd.load = 1'b1;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div = 1'b1;
				state_d = S_REM;
			end
			S_REM: begin
				cmd.rem = 1'b1;
				state_d = S_NBR;
			end
			S_NBR: begin
				cmd.nbr = 1'b1;
				state_d = S_READ;
			end
			S_READ: begin
				cmd.rd = 1'b1;
				if (status.rd_done) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				if (status.out_free) begin
					cmd.eval = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	a_eval_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL && !status.out_free) |=> (state_q == S_EVAL))
		else $error("Result stage left while the output word was still pending.");

	a_read_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ && status.rd_done) |=> (state_q == S_EVAL))
		else $error("Read sequence did not hand over to evaluation.");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q == S_DIV))
		else $error("Accepted word did not start the index split.");

endmodule

### hw/rtl/ismu_datapath.sv
// Datapath of the Ising Metropolis update unit: spin memory, index split,
// neighbor reads, acceptance test, running totals and the output register.
// Depends on ismu_pkg; driven by ismu_controller through command signals.
module ismu_datapath #(
	parameter int COLS = 64,
	parameter int ROWS = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ismu_pkg::ismu_cmd_t                   cmd,
	output ismu_pkg::ismu_status_t                status,
	input  logic                                 in_req_type,
	input  logic [ismu_pkg::SITE_W-1:0]          in_site,
	input  logic [ismu_pkg::RAND_W-1:0]          in_rand_req,
	input  logic                                 in_spin_value,
	input  logic                                 cfg_valid,
	input  logic [ismu_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ismu_pkg::REG_W-1:0]           cfg_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 out_flipped,
	output logic                                 out_spin_after,
	output logic signed [ismu_pkg::SPIN_SUM_W-1:0] out_spin_sum,
	output logic signed [ismu_pkg::BOND_SUM_W-1:0] out_bond_sum
);
	import ismu_pkg::*;

	localparam int SITE_COUNT = ROWS * COLS;
	localparam int MEM_DEPTH  = (SITE_COUNT < (1 << SITE_W)) ? SITE_COUNT : (1 << SITE_W);
	localparam int AW         = $clog2(MEM_DEPTH);
	localparam int IW         = (SITE_COUNT > MEM_DEPTH) ? $clog2(SITE_COUNT) : SITE_W;
	localparam int PROD_W     = SITE_W + RECIP_SHIFT;
	localparam logic [RECIP_SHIFT-1:0] RECIP = RECIP_SHIFT'((1 << RECIP_SHIFT) / COLS);
	localparam logic [SITE_W-1:0] COLS_V  = SITE_W'(COLS);
	localparam logic [SITE_W-1:0] LAST_ROW = SITE_W'(ROWS - 1);
	localparam logic [SITE_W-1:0] LAST_COL = SITE_W'(COLS - 1);

	logic                  spin_mem_q [MEM_DEPTH];
	logic                  rd_data_q;
	logic [AW-1:0]         clr_cnt_q;

	logic                  kind_q;
	logic [SITE_W-1:0]     site_q;
	logic [RAND_W-1:0]     rand_q;
	logic                  wval_q;
	logic [SITE_W-1:0]     q_est_q;
	logic [SITE_W-1:0]     r_q;
	logic                  valid_q;
	logic [AW-1:0]         nb_addr_q [READ_COUNT];
	logic                  nb_hi_q [READ_COUNT];
	logic [2:0]            rd_cnt_q;
	logic                  rd_hi_s1;
	logic                  cur_q;
	logic signed [3:0]     nbr_q;
	logic [REG_W-1:0]      accept_q [REG_COUNT];
	logic [SPIN_SUM_W-1:0] total_spin_q;
	logic [BOND_SUM_W-1:0] total_bond_q;

	logic [PROD_W-1:0]     prod;
	logic [2*SITE_W-1:0]   qc;
	logic                  r_big;
	logic [SITE_W-1:0]     row;
	logic [SITE_W-1:0]     col;
	logic [IW-1:0]         nb [READ_COUNT];
	logic                  nb_hi [READ_COUNT];
	logic [2:0]            rd_sel;
	logic                  rd_bit;
	logic signed [3:0]     align;
	logic [3:0]            align_ofs;
	logic [2:0]            sel;
	logic [REG_W-1:0]      reg_sel;
	logic [THR_W-1:0]      thr;
	logic                  flip;
	logic [BOND_SUM_W-1:0] nbr2;
	logic [BOND_SUM_W-1:0] dbond;
	logic [SPIN_SUM_W-1:0] dspin;
	logic                  eval_go;

	assign prod  = PROD_W'(site_q) * PROD_W'(RECIP);
	assign qc    = (2*SITE_W)'(q_est_q) * (2*SITE_W)'(COLS_V);
	assign r_big = (r_q >= COLS_V);
	assign row   = r_big ? q_est_q + 1'b1 : q_est_q;
	assign col   = r_big ? r_q - COLS_V : r_q;

	always_comb begin
		nb[0] = IW'(site_q);
		nb[1] = (col == '0) ? IW'(site_q) + IW'(COLS - 1) : IW'(site_q) - 1'b1;
		nb[2] = (col == LAST_COL) ? IW'(site_q) - IW'(COLS - 1) : IW'(site_q) + 1'b1;
		nb[3] = (row == '0) ? IW'(site_q) + IW'((ROWS - 1) * COLS) : IW'(site_q) - IW'(COLS);
		nb[4] = (row == LAST_ROW) ? IW'(site_q) - IW'((ROWS - 1) * COLS)
			: IW'(site_q) + IW'(COLS);
		for (int i = 0; i < READ_COUNT; i++) begin
			nb_hi[i] = ({1'b0, nb[i]} >= (IW+1)'(MEM_DEPTH));
		end
	end

	assign rd_sel = (rd_cnt_q < 3'(READ_COUNT)) ? rd_cnt_q : 3'd0;
	assign rd_bit = rd_hi_s1 | rd_data_q;

	always_comb begin
		align     = cur_q ? nbr_q : -nbr_q;
		align_ofs = 4'(align) + 4'd4;
		sel       = (align_ofs[3:1] > 3'(REG_COUNT - 1)) ? 3'(REG_COUNT - 1) : align_ofs[3:1];
		reg_sel   = accept_q[sel];
		thr       = cur_q ? reg_sel[THR_W-1:0] : reg_sel[REG_W-1:THR_W];
		if (kind_q) begin
			flip = valid_q & (wval_q != cur_q);
		end else begin
			flip = valid_q & ({1'b0, rand_q} < thr);
		end
		nbr2  = BOND_SUM_W'({{(BOND_SUM_W-4){nbr_q[3]}}, nbr_q}) << 1;
		dbond = cur_q ? -nbr2 : nbr2;
		dspin = cur_q ? -SPIN_SUM_W'(2) : SPIN_SUM_W'(2);
	end

	assign eval_go = cmd.eval;

	assign status.clear_done = (clr_cnt_q == AW'(MEM_DEPTH - 1));
	assign status.rd_done    = (rd_cnt_q == 3'(READ_COUNT));
	assign status.out_free   = !out_valid || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			spin_mem_q[clr_cnt_q] <= 1'b1;
		end else if (eval_go && flip) begin
			spin_mem_q[site_q[AW-1:0]] <= ~cur_q;
		end
		rd_data_q <= spin_mem_q[nb_addr_q[rd_sel]];
		rd_hi_s1  <= nb_hi_q[rd_sel];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_req_type;
			site_q <= in_site;
			rand_q <= in_rand_req;
			wval_q <= in_spin_value;
		end
		if (cmd.div) begin
			q_est_q <= prod[PROD_W-1:RECIP_SHIFT];
		end
		if (cmd.rem) begin
			r_q <= site_q - qc[SITE_W-1:0];
		end
		if (cmd.nbr) begin
			valid_q <= (32'(site_q) < 32'(SITE_COUNT));
			for (int i = 0; i < READ_COUNT; i++) begin
				nb_hi_q[i]   <= nb_hi[i];
				nb_addr_q[i] <= nb_hi[i] ? '0 : nb[i][AW-1:0];
			end
			nbr_q <= '0;
		end else if (cmd.rd && rd_cnt_q != 3'd0) begin
			if (rd_cnt_q == 3'd1) begin
				cur_q <= rd_bit;
			end else begin
				nbr_q <= rd_bit ? nbr_q + 4'sd1 : nbr_q - 4'sd1;
			end
		end
		if (eval_go) begin
			out_flipped    <= flip;
			out_spin_after <= valid_q & (cur_q ^ flip);
			out_spin_sum   <= flip ? total_spin_q + dspin : total_spin_q;
			out_bond_sum   <= flip ? total_bond_q + dbond : total_bond_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q    <= '0;
			rd_cnt_q     <= '0;
			out_valid    <= 1'b0;
			total_spin_q <= SPIN_SUM_W'(SITE_COUNT);
			total_bond_q <= BOND_SUM_W'(2 * SITE_COUNT);
			for (int i = 0; i < REG_COUNT; i++) begin
				accept_q[i] <= ACCEPT_RESET[i];
			end
		end else begin
			if (cmd.clear && !status.clear_done) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.nbr) begin
				rd_cnt_q <= '0;
			end else if (cmd.rd && !status.rd_done) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			if (eval_go) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (eval_go && flip) begin
				total_spin_q <= total_spin_q + dspin;
				total_bond_q <= total_bond_q + dbond;
			end
			if (cfg_valid && cfg_index < CFG_IDX_W'(REG_COUNT)) begin
				accept_q[cfg_index] <= cfg_data;
			end
		end
	end

	a_rd_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_cnt_q <= 3'(READ_COUNT))
		else $error("Read counter ran past the last neighbor.");

	a_out_from_eval: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.eval))
		else $error("Output word appeared without an evaluation.");

	a_totals_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(cmd.eval) |-> ($stable(total_spin_q) && $stable(total_bond_q)))
		else $error("Running totals changed outside an evaluation.");

endmodule

### hw/rtl/ising_metropolis_update_unit.sv
// Top level of the Ising Metropolis update unit.
// Instantiates ismu_controller and ismu_datapath; depends on ismu_pkg.

// The unit holds a ROWS x COLS periodic lattice of one-bit spins and takes
// one word at a time: a Metropolis trial (tuser low) or a direct spin write
// (tuser high), each answered by exactly one result word carrying the flip
// flag, the new spin and the running spin and bond totals. After a word is
// accepted, the divide, remainder and neighbor states split the site
// index into row and column and form the neighbor addresses, the read state
// reads the site and its four neighbors through the single read port of the
// spin memory, and the evaluation state evaluates, writes back and loads
// the output register. The next word can be taken in the cycle after that,
// so the unit handles one word at a time; while the previous result
// still waits for m_axis_tready, evaluation holds and the input stalls.
// After reset the memory is swept to all spins up, one site per cycle, over
// min(ROWS*COLS, 4096) sites, during which no word is accepted;
// configuration writes are taken at any time.
module ising_metropolis_update_unit #(
	parameter int COLS = 64,
	parameter int ROWS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// site [11:0], rand_req [27:12], spin_value [28], zero fill [31:29].
	input  logic [ismu_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// req_type [0].
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// flipped [0], spin_after [1], spin_sum [15:2], bond_sum [30:16], zero [31].
	output logic [ismu_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ismu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ismu_pkg::REG_W-1:0]          cfg_data
);
	import ismu_pkg::*;

	ismu_cmd_t    cmd;
	ismu_status_t status;

	logic                         out_flipped;
	logic                         out_spin_after;
	logic signed [SPIN_SUM_W-1:0] out_spin_sum;
	logic signed [BOND_SUM_W-1:0] out_bond_sum;

	assign cfg_ready = 1'b1;

	ismu_controller u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.status        (status),
		.cmd           (cmd)
	);

	ismu_datapath #(
		.COLS (COLS),
		.ROWS (ROWS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.in_req_type    (s_axis_tuser),
		.in_site        (s_axis_tdata[SITE_W-1:0]),
		.in_rand_req    (s_axis_tdata[SITE_W+RAND_W-1:SITE_W]),
		.in_spin_value  (s_axis_tdata[SITE_W+RAND_W]),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_flipped    (out_flipped),
		.out_spin_after (out_spin_after),
		.out_spin_sum   (out_spin_sum),
		.out_bond_sum   (out_bond_sum)
	);

	assign m_axis_tdata = {1'b0, out_bond_sum, out_spin_sum, out_spin_after, out_flipped};

endmodule

### verif/ising_metropolis_update_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for ising_metropolis_update_unit: a directed table, then random
// trials and spin writes under several threshold settings, checked against a lattice model.
// Depends on ismu_pkg and the RTL of the unit.
module ising_metropolis_update_unit_tb;
	import ismu_pkg::*;

	localparam int COLS = 64;
	localparam int ROWS = 64;
	localparam int SITES = ROWS * COLS;
	localparam int CLK_PERIOD = 10;
	localparam int RESET_CYCLES = 3;
	localparam int DRAIN_CYCLES = 24;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int WORDS_PER_PHASE = 110;
	localparam longint TIMEOUT_NS = 5_000_000;
	localparam real BOND_SCALE = 2.0;
	localparam logic [THR_W-1:0] ALWAYS_LEVEL = 17'h10000;

	typedef enum logic {
		REQ_TRIAL = 1'b0,
		REQ_WRITE = 1'b1
	} req_kind_t;

	typedef enum int {
		ACC_K_MINUS4,
		ACC_K_MINUS2,
		ACC_K_ZERO,
		ACC_K_PLUS2,
		ACC_K_PLUS4
	} acc_reg_t;

	typedef struct packed {
		logic                          flipped;
		logic                          spin_after;
		logic signed [SPIN_SUM_W-1:0]  spin_sum;
		logic signed [BOND_SUM_W-1:0]  bond_sum;
	} ismu_result_t;

	typedef struct packed {
		req_kind_t          kind;
		logic [SITE_W-1:0]  site;
		logic [RAND_W-1:0]  rnd;
		logic               spin_value;
		logic               typed;
		ismu_result_t       want;
	} dir_row_t;

	localparam ismu_result_t NO_RESULT = '0;
	localparam ismu_result_t AT_RESET = '{1'b0, 1'b1, 14'sd4096, 15'sd8192};
	localparam ismu_result_t FIRST_FLIP = '{1'b1, 1'b0, 14'sd4094, 15'sd8184};

	localparam int DIRECTED_COUNT = 24;
	localparam dir_row_t DIRECTED [DIRECTED_COUNT] = '{
		'{REQ_TRIAL, 12'd0,    16'd0,     1'b0, 1'b1, AT_RESET},
		'{REQ_TRIAL, 12'd4095, 16'd65535, 1'b1, 1'b1, AT_RESET},
		'{REQ_WRITE, 12'd0,    16'd0,     1'b1, 1'b1, AT_RESET},
		'{REQ_WRITE, 12'd0,    16'hAAAA,  1'b0, 1'b1, FIRST_FLIP},
		'{REQ_TRIAL, 12'd0,    16'd32768, 1'b0, 1'b0, NO_RESULT},
		'{REQ_TRIAL, 12'd0,    16'd32767, 1'b1, 1'b0, NO_RESULT},
		'{REQ_WRITE, 12'd63,   16'h5555,  1'b0, 1'b0, NO_RESULT},
		'{REQ_WRITE, 12'd4032, 16'd0,     1'b0, 1'b0, NO_RESULT},
		'{REQ_WRITE, 12'd1,    16'd0,     1'b0, 1'b0, NO_RESULT},
		'{REQ_WRITE, 12'd64,   16'd0,     1'b0, 1'b0, NO_RESULT},
		'{REQ_TRIAL, 12'd0,    16'd65535, 1'b0, 1'b0, NO_RESULT},
		'{REQ_TRIAL, 12'd0,    16'd0,     1'b0, 1'b0, NO_RESULT},
		'{REQ_WRITE, 12'd4095, 16'd0,     1'b0, 1'b0, NO_RESULT},
		'{REQ_TRIAL, 12'd4094, 16'd0,     1'b0, 1'b0, NO_RESULT},
		'{REQ_TRIAL, 12'd4095, 16'd65535, 1'b0, 1'b0, NO_RESULT},
		'{REQ_TRIAL, 12'd4095, 16'd0,     1'b0, 1'b0, NO_RESULT},
		'{REQ_TRIAL, 12'd1,    16'd0,     1'b0, 1'b0, NO_RESULT},
		'{REQ_TRIAL, 12'd0,    16'd0,     1'b0, 1'b0, NO_RESULT},
		'{REQ_TRIAL, 12'd65,   16'd100,   1'b0, 1'b0, NO_RESULT},
		'{REQ_WRITE, 12'd2048, 16'd0,     1'b1, 1'b0, NO_RESULT},
		'{REQ_WRITE, 12'd2048, 16'd0,     1'b0, 1'b0, NO_RESULT},
		'{REQ_WRITE, 12'd2048, 16'd0,     1'b1, 1'b0, NO_RESULT},
		'{REQ_TRIAL, 12'd64,   16'hFFFF,  1'b0, 1'b0, NO_RESULT},
		'{REQ_TRIAL, 12'd4032, 16'd1,     1'b0, 1'b0, NO_RESULT}
	};

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_DATA_W-1:0]   s_axis_tdata;
	logic                   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_DATA_W-1:0]  m_axis_tdata;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [REG_W-1:0]       cfg_data;

	logic                          spin_image [SITES];
	logic signed [SPIN_SUM_W-1:0]  spin_total;
	logic signed [BOND_SUM_W-1:0]  bond_total;
	logic [REG_W-1:0]              accept_levels [REG_COUNT];
	logic [REG_W-1:0]              next_levels [REG_COUNT];
	ismu_result_t                  awaited_updates [$];
	int                            error_count = 0;
	int                            burst_left = 0;
	bit                            hold_off_request = 1'b0;

	ising_metropolis_update_unit #(
		.COLS(COLS),
		.ROWS(ROWS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int unsigned site_at(input int row, input int col);
		return ((row + ROWS) % ROWS) * COLS + (col + COLS) % COLS;
	endfunction

	function automatic int spin_sign(input int unsigned site);
		return spin_image[site] ? 1 : -1;
	endfunction

	// Applies one word to the lattice image and returns the result the unit must send.
	function automatic ismu_result_t metropolis_step(input req_kind_t kind,
			input int unsigned site, input logic [RAND_W-1:0] rnd, input logic spin_value);
		ismu_result_t res;
		int row;
		int col;
		int nbr;
		int align;
		int sgn;
		logic cur;
		logic [THR_W-1:0] level;
		logic [REG_W-1:0] pair;
		logic hit;
		res = '0;
		if (site < SITES) begin
			row = site / COLS;
			col = site % COLS;
			nbr = spin_sign(site_at(row, col - 1)) + spin_sign(site_at(row, col + 1))
				+ spin_sign(site_at(row - 1, col)) + spin_sign(site_at(row + 1, col));
			cur = spin_image[site];
			sgn = cur ? 1 : -1;
			if (kind == REQ_TRIAL) begin
				align = sgn * nbr;
				pair = accept_levels[acc_reg_t'((align + 4) / 2)];
				level = cur ? pair[THR_W-1:0] : pair[REG_W-1:THR_W];
				hit = ({1'b0, rnd} < level);
			end else begin
				hit = (spin_value != cur);
			end
			if (hit) begin
				spin_total = spin_total + SPIN_SUM_W'(-2 * sgn);
				bond_total = bond_total + BOND_SUM_W'(-2 * sgn * nbr);
				spin_image[site] = ~cur;
			end
			res.flipped = hit;
			res.spin_after = spin_image[site];
		end
		res.spin_sum = spin_total;
		res.bond_sum = bond_total;
		return res;
	endfunction

	function automatic logic [THR_W-1:0] accept_level(input real energy, input real temp);
		if (energy <= 0.0)
			return ALWAYS_LEVEL;
		return THR_W'($rtoi($exp(-energy / temp) * 65536.0));
	endfunction

	function automatic int next_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			burst_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 45)
			return 0;
		if (r < 80)
			return $urandom_range(1, 2);
		if (r < 95)
			return $urandom_range(3, 8);
		return $urandom_range(10, 40);
	endfunction

	// Mostly a patch around the wrapping corner and neighbors of the last site.
	function automatic int unsigned pick_site(input int unsigned prev);
		int row;
		int col;
		row = prev / COLS;
		col = prev % COLS;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return site_at(ROWS - 2 + $urandom_range(0, 3),
				COLS - 2 + $urandom_range(0, 3));
			4, 5, 6: begin
				case ($urandom_range(0, 4))
					0: return prev;
					1: return site_at(row, col - 1);
					2: return site_at(row, col + 1);
					3: return site_at(row - 1, col);
					default: return site_at(row + 1, col);
				endcase
			end
			default: return $urandom_range(0, SITES - 1);
		endcase
	endfunction

	task automatic offer_word(input req_kind_t kind, input logic [SITE_W-1:0] site,
			input logic [RAND_W-1:0] rnd, input logic spin_value, input logic typed,
			input ismu_result_t want);
		int gap;
		ismu_result_t predicted;
		gap = next_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= IN_DATA_W'({spin_value, rnd, site});
		do @(posedge clk); while (!s_axis_tready);
		predicted = metropolis_step(kind, site, rnd, spin_value);
		awaited_updates.push_back(typed ? want : predicted);
	endtask

	task automatic cfg_word(input logic [CFG_IDX_W-1:0] index, input logic [REG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (index < REG_COUNT)
			accept_levels[index] = value;
	endtask

	task automatic program_levels(input bit stray);
		for (int i = ACC_K_MINUS4; i <= ACC_K_PLUS4; i++)
			cfg_word(CFG_IDX_W'(i), next_levels[i]);
		if (stray)
			for (int i = REG_COUNT; i < 2 ** CFG_IDX_W; i++)
				cfg_word(CFG_IDX_W'(i), REG_W'({$urandom, $urandom}));
		cfg_valid <= 1'b0;
	endtask

	// Thresholds min(1, exp(-dE/T)) with J = 1, for the spin up in the low half.
	task automatic thermal_levels(input real temp, input real field);
		real bond_energy;
		for (int i = ACC_K_MINUS4; i <= ACC_K_PLUS4; i++) begin
			bond_energy = BOND_SCALE * real'(2 * i - 4);
			next_levels[i] = {accept_level(bond_energy - BOND_SCALE * field, temp),
				accept_level(bond_energy + BOND_SCALE * field, temp)};
		end
	endtask

	task automatic run_random(input int count);
		int unsigned site;
		req_kind_t kind;
		logic [RAND_W-1:0] rnd;
		site = $urandom_range(0, SITES - 1);
		repeat (count) begin
			site = pick_site(site);
			kind = ($urandom_range(0, 4) == 0) ? REQ_WRITE : REQ_TRIAL;
			case ($urandom_range(0, 9))
				0: rnd = '0;
				1: rnd = '1;
				2: rnd = RAND_W'(32'h8000 + $urandom_range(0, 7) - 32'd4);
				default: rnd = RAND_W'($urandom);
			endcase
			offer_word(kind, SITE_W'(site), rnd, 1'($urandom), 1'b0, NO_RESULT);
		end
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic settle();
		while (awaited_updates.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			error_count++;
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	task automatic check_result(input logic [OUT_DATA_W-1:0] word);
		ismu_result_t got;
		ismu_result_t want;
		got.flipped = word[0];
		got.spin_after = word[1];
		got.spin_sum = word[15:2];
		got.bond_sum = word[30:16];
		if (awaited_updates.size() == 0) begin
			error_count++;
			$display("%0t ns: unexpected result word, expected none, got %h", $time, word);
			return;
		end
		want = awaited_updates.pop_front();
		compare_field("flipped", want.flipped, got.flipped);
		compare_field("spin_after", want.spin_after, got.spin_after);
		compare_field("spin_sum", want.spin_sum, got.spin_sum);
		compare_field("bond_sum", want.bond_sum, got.bond_sum);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_result(m_axis_tdata);
	end

	initial begin
		int r;
		int span;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off_request) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_request = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 45) begin
					m_axis_tready <= 1'b1;
					span = $urandom_range(1, 8);
				end else if (r < 80) begin
					m_axis_tready <= 1'b0;
					span = $urandom_range(1, 3);
				end else if (r < 95) begin
					m_axis_tready <= 1'b0;
					span = $urandom_range(4, 20);
				end else begin
					m_axis_tready <= 1'b1;
					span = $urandom_range(30, 80);
				end
				repeat (span) @(posedge clk);
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tuser <= REQ_TRIAL;
		s_axis_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		foreach (spin_image[i])
			spin_image[i] = 1'b1;
		spin_total = SPIN_SUM_W'(SITES);
		bond_total = BOND_SUM_W'(2 * SITES);
		foreach (accept_levels[i])
			accept_levels[i] = ACCEPT_RESET[i];
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			offer_word(DIRECTED[i].kind, DIRECTED[i].site, DIRECTED[i].rnd,
				DIRECTED[i].spin_value, DIRECTED[i].typed, DIRECTED[i].want);
		s_axis_tvalid <= 1'b0;
		settle();

		foreach (next_levels[i])
			next_levels[i] = '0;
		program_levels(1'b1);
		run_random(WORDS_PER_PHASE);
		settle();

		foreach (next_levels[i])
			next_levels[i] = '1;
		program_levels(1'b0);
		hold_off_request = 1'b1;
		run_random(WORDS_PER_PHASE);
		settle();

		thermal_levels(1.0 + real'($urandom_range(0, 300)) / 100.0, 0.0);
		program_levels(1'b0);
		run_random(WORDS_PER_PHASE);
		settle();

		thermal_levels(2.27, (real'($urandom_range(0, 40)) - 20.0) / 100.0);
		program_levels(1'b1);
		run_random(WORDS_PER_PHASE);
		settle();

		foreach (next_levels[i])
			next_levels[i] = REG_W'({$urandom, $urandom});
		program_levels(1'b0);
		run_random(WORDS_PER_PHASE);
		settle();

		if (error_count == 0 && awaited_updates.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/ismu_pkg.sv
hw/rtl/ismu_controller.sv
hw/rtl/ismu_datapath.sv
hw/rtl/ising_metropolis_update_unit.sv
verif/ising_metropolis_update_unit_tb.sv
